>>> rtl/core/ash_pkg.sv
// Shared constants, types and register codes for the angle sensor smoother.
`default_nettype none

package ash_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int FILTER_SHIFT_DEF = 7;

    localparam int FRAC_BITS = 8;

    // Field widths
    localparam int REF_W        = 12;
    localparam int TENTHS_W     = 12;
    localparam int HYST_W       = 10;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int OUT_TDATA_W  = 16;

    // Angle units are 1/10000 degree
    localparam int UNITS_PER_TURN  = 3600000;
    localparam int HALF_TURN       = 1800000;
    localparam int UNITS_PER_TENTH = 1000;
    localparam int HALF_TENTH      = 500;
    localparam int UNIT_W          = 22;
    localparam int REF_TENTHS_MAX  = 3600;

    // Hysteresis band is held in angle units
    localparam int HYST_SCALE     = 100;
    localparam int HYST_RESET     = 20;
    localparam int HYST_UNITS_W   = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_RAW    = 2'd0,
        CFG_REF_TENTHS = 2'd1,
        CFG_HYST       = 2'd2
    } cfg_idx_t;

    // Configuration as the datapath uses it
    typedef struct packed {
        logic [REF_W-1:0]        ref_raw;
        logic [UNIT_W-1:0]       ref_units;
        logic [HYST_UNITS_W-1:0] hyst_units;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/ash_filter.sv
// First-order IIR smoothing filter on the raw samples, one stage.
`default_nettype none

module ash_filter #(
    parameter int SAMPLE_BITS  = ash_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_SHIFT = ash_pkg::FILTER_SHIFT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   clear,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_pos
);
    import ash_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_W = ACC_W + FILTER_SHIFT;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             loaded_reg, loaded_next;
    logic             valid_reg, valid_next;
    logic [SUM_W-1:0] mix;
    logic             take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // acc * (2^shift - 1) + sample << 8, then drop the shift bits
    always_comb begin
        mix = (SUM_W'(acc_reg) << FILTER_SHIFT) - SUM_W'(acc_reg)
              + SUM_W'({in_sample, {FRAC_BITS{1'b0}}});
        acc_next    = acc_reg;
        loaded_next = loaded_reg;
        if (take) begin
            acc_next    = loaded_reg ? mix[FILTER_SHIFT +: ACC_W]
                                     : {in_sample, {FRAC_BITS{1'b0}}};
            loaded_next = 1'b1;
        end
        if (clear) begin
            loaded_next = 1'b0;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            loaded_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            acc_reg    <= acc_next;
            loaded_reg <= loaded_next;
            valid_reg  <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pos   = acc_reg[FRAC_BITS +: SAMPLE_BITS];

endmodule

`default_nettype wire

>>> rtl/core/ash_scale.sv
// Position to wrapped angle: rounded scaling by turn/full-scale and reference offset.
`default_nettype none

module ash_scale #(
    parameter int SAMPLE_BITS = ash_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ash_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SAMPLE_BITS-1:0]    in_pos,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ash_pkg::UNIT_W-1:0] out_angle
);
    import ash_pkg::*;

    localparam int NST = 7;

    localparam longint FULL      = (longint'(1) << SAMPLE_BITS) - 1;
    localparam int     MAG_W     = (SAMPLE_BITS > REF_W) ? SAMPLE_BITS : REF_W;
    localparam int     DIFF_W    = MAG_W + 1;
    localparam longint SCALE_Q   = UNITS_PER_TURN / FULL;
    localparam longint SCALE_R   = UNITS_PER_TURN % FULL;
    localparam longint HALF_FULL = FULL / 2;
    localparam int     Y_W       = MAG_W + SAMPLE_BITS;
    localparam longint RECIP_F   = (longint'(1) << Y_W) / FULL;
    localparam int     RECIP_F_W = MAG_W + 1;
    localparam int     PF_W      = Y_W + RECIP_F_W;
    localparam int     Q0_W      = MAG_W + 1;
    localparam longint MAG_MAX   = (longint'(1) << MAG_W) - 1;
    localparam int     MQ_W      = $clog2(MAG_MAX * SCALE_Q + 1);
    localparam longint U_MAX     = (MAG_MAX * UNITS_PER_TURN + HALF_FULL) / FULL;
    localparam int     U_W       = $clog2(U_MAX + 1);
    localparam longint RECIP_C   = (longint'(1) << U_W) / UNITS_PER_TURN;
    localparam int     RECIP_C_W = $clog2(RECIP_C + 1);
    localparam int     PC_W      = U_W + RECIP_C_W;
    localparam int     QC_W      = $clog2(U_MAX / UNITS_PER_TURN + 1);
    localparam int     W_W       = UNIT_W + 1;
    localparam int     UX_W      = (U_W > W_W) ? U_W : W_W;
    localparam int     PRE_W     = UNIT_W + 2;

    localparam logic [MQ_W-1:0]   SCALE_Q_V = MQ_W'(SCALE_Q);
    localparam logic [Y_W-1:0]    SCALE_R_V = Y_W'(SCALE_R);
    localparam logic [Y_W-1:0]    HALF_V    = Y_W'(HALF_FULL);
    localparam logic [Y_W-1:0]    FULL_Y    = Y_W'(FULL);
    localparam logic [PF_W-1:0]   RECIP_F_V = PF_W'(RECIP_F);
    localparam logic [PC_W-1:0]   RECIP_C_V = PC_W'(RECIP_C);
    localparam logic [UX_W-1:0]   TURN_X    = UX_W'(UNITS_PER_TURN);
    localparam logic [W_W-1:0]    TURN_W    = W_W'(UNITS_PER_TURN);
    localparam logic [PRE_W-1:0]  TURN_P    = PRE_W'(UNITS_PER_TURN);

    logic [NST-1:0] valid_reg, valid_next;
    logic [NST:0]   rdy;

    // stage 0: magnitude of the offset and its two partial products
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         mag;
    logic                     s0_neg_reg, s0_neg_next;
    logic [MQ_W-1:0]          s0_mq_reg, s0_mq_next;
    logic [Y_W-1:0]           s0_y_reg, s0_y_next;
    // stage 1: reciprocal estimate of y / full scale
    logic [PF_W-1:0]          prod_f;
    logic                     s1_neg_reg;
    logic [MQ_W-1:0]          s1_mq_reg;
    logic [Y_W-1:0]           s1_y_reg;
    logic [Q0_W-1:0]          s1_q0_reg, s1_q0_next;
    // stage 2: correct the quotient, rounded magnitude in angle units
    logic [Y_W-1:0]           rem_f;
    logic                     s2_neg_reg;
    logic [U_W-1:0]           s2_u_reg, s2_u_next;
    // stage 3: turns contained in the magnitude
    logic [PC_W-1:0]          prod_c;
    logic                     s3_neg_reg;
    logic [U_W-1:0]           s3_u_reg;
    logic [QC_W-1:0]          s3_qc_reg, s3_qc_next;
    // stage 4: remainder below two turns
    logic [UX_W-1:0]          rem_c;
    logic                     s4_neg_reg;
    logic [W_W-1:0]           s4_w_reg, s4_w_next;
    // stage 5: apply sign and reference angle
    logic [UNIT_W-1:0]        w_mod;
    logic [PRE_W-1:0]         s5_pre_reg, s5_pre_next;
    // stage 6: wrap into one turn
    logic [UNIT_W-1:0]        s6_angle_reg, s6_angle_next;

    always_comb begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NST; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        diff        = $signed(DIFF_W'(in_pos)) - $signed(DIFF_W'(cfg.ref_raw));
        s0_neg_next = diff[DIFF_W-1];
        mag         = s0_neg_next ? MAG_W'(-diff) : MAG_W'(diff);
        s0_mq_next  = MQ_W'(mag) * SCALE_Q_V;
        s0_y_next   = Y_W'(mag) * SCALE_R_V + HALF_V;

        prod_f     = PF_W'(s0_y_reg) * RECIP_F_V;
        s1_q0_next = prod_f[Y_W +: Q0_W];

        // estimate is low by at most one
        rem_f     = s1_y_reg - Y_W'(s1_q0_reg) * FULL_Y;
        s2_u_next = U_W'(s1_mq_reg) + U_W'(s1_q0_reg) + U_W'(rem_f >= FULL_Y);

        prod_c     = PC_W'(s2_u_reg) * RECIP_C_V;
        s3_qc_next = prod_c[U_W +: QC_W];

        rem_c     = UX_W'(s3_u_reg) - UX_W'(s3_qc_reg) * TURN_X;
        s4_w_next = rem_c[W_W-1:0];

        w_mod       = (s4_w_reg >= TURN_W) ? UNIT_W'(s4_w_reg - TURN_W) : UNIT_W'(s4_w_reg);
        s5_pre_next = s4_neg_reg ? PRE_W'(cfg.ref_units) - PRE_W'(w_mod)
                                 : PRE_W'(cfg.ref_units) + PRE_W'(w_mod);

        if (s5_pre_reg[PRE_W-1]) begin
            s6_angle_next = UNIT_W'(s5_pre_reg + TURN_P);
        end else if (s5_pre_reg >= TURN_P) begin
            s6_angle_next = UNIT_W'(s5_pre_reg - TURN_P);
        end else begin
            s6_angle_next = UNIT_W'(s5_pre_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_neg_reg <= s0_neg_next;
            s0_mq_reg  <= s0_mq_next;
            s0_y_reg   <= s0_y_next;
        end
        if (rdy[1]) begin
            s1_neg_reg <= s0_neg_reg;
            s1_mq_reg  <= s0_mq_reg;
            s1_y_reg   <= s0_y_reg;
            s1_q0_reg  <= s1_q0_next;
        end
        if (rdy[2]) begin
            s2_neg_reg <= s1_neg_reg;
            s2_u_reg   <= s2_u_next;
        end
        if (rdy[3]) begin
            s3_neg_reg <= s2_neg_reg;
            s3_u_reg   <= s2_u_reg;
            s3_qc_reg  <= s3_qc_next;
        end
        if (rdy[4]) begin
            s4_neg_reg <= s3_neg_reg;
            s4_w_reg   <= s4_w_next;
        end
        if (rdy[5]) begin
            s5_pre_reg <= s5_pre_next;
        end
        if (rdy[6]) begin
            s6_angle_reg <= s6_angle_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_angle = s6_angle_reg;

endmodule

`default_nettype wire

>>> rtl/core/ash_disp.sv
// Rounding to tenths and display hysteresis; holds the result register.
`default_nettype none

module ash_disp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  ash_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ash_pkg::UNIT_W-1:0]   in_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ash_pkg::TENTHS_W-1:0] out_tenths
);
    import ash_pkg::*;

    localparam int     NST       = 3;
    localparam longint RECIP_T   = (longint'(1) << UNIT_W) / UNITS_PER_TENTH;
    localparam int     RECIP_T_W = $clog2(RECIP_T + 1);
    localparam int     PT_W      = UNIT_W + RECIP_T_W;
    localparam int     DELTA_W   = UNIT_W + 2;

    localparam logic [UNIT_W-1:0]         HALF_U  = UNIT_W'(HALF_TENTH);
    localparam logic [UNIT_W-1:0]         TENTH_U = UNIT_W'(UNITS_PER_TENTH);
    localparam logic [PT_W-1:0]           RECIP_V = PT_W'(RECIP_T);
    localparam logic signed [DELTA_W-1:0] HALF_S  = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] TURN_S  = DELTA_W'(UNITS_PER_TURN);

    logic [NST-1:0] valid_reg, valid_next;
    logic [NST:0]   rdy;

    // stage 0: angle + half tenth and its quotient estimate
    logic [UNIT_W-1:0]   t_sum;
    logic [PT_W-1:0]     prod_t;
    logic [UNIT_W-1:0]   s0_angle_reg;
    logic [UNIT_W-1:0]   s0_t_reg;
    logic [TENTHS_W-1:0] s0_q_reg, s0_q_next;
    // stage 1: corrected tenths and the same value in angle units
    logic [UNIT_W-1:0]   rem_t;
    logic                bump;
    logic [UNIT_W-1:0]   s1_angle_reg;
    logic [TENTHS_W-1:0] s1_round_reg, s1_round_next;
    logic [UNIT_W-1:0]   s1_runits_reg, s1_runits_next;
    // output stage: shown value
    logic signed [DELTA_W-1:0] delta_raw, delta, thr;
    logic                      moved;
    logic [TENTHS_W-1:0]       shown_reg, shown_next;
    logic [UNIT_W-1:0]         shown_units_reg, shown_units_next;
    logic                      shown_valid_reg, shown_valid_next;

    always_comb begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NST; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        t_sum     = in_angle + HALF_U;
        prod_t    = PT_W'(t_sum) * RECIP_V;
        s0_q_next = prod_t[UNIT_W +: TENTHS_W];

        rem_t          = s0_t_reg - UNIT_W'(s0_q_reg) * TENTH_U;
        bump           = rem_t >= TENTH_U;
        s1_round_next  = s0_q_reg + TENTHS_W'(bump);
        s1_runits_next = s0_t_reg - rem_t + (bump ? TENTH_U : '0);
    end

    // circular distance from the shown value, folded into half a turn
    always_comb begin
        delta_raw = $signed({2'b00, s1_angle_reg}) - $signed({2'b00, shown_units_reg});
        delta     = delta_raw;
        if (delta > HALF_S) begin
            delta = delta - TURN_S;
        end
        if (delta < -HALF_S) begin
            delta = delta + TURN_S;
        end
        thr   = $signed(DELTA_W'(cfg.hyst_units));
        moved = (delta > thr) || (delta < -thr);

        shown_next       = shown_reg;
        shown_units_next = shown_units_reg;
        shown_valid_next = shown_valid_reg;
        if (rdy[2] && valid_reg[1]) begin
            if (!shown_valid_reg || moved) begin
                shown_next       = s1_round_reg;
                shown_units_next = s1_runits_reg;
            end
            shown_valid_next = 1'b1;
        end
        if (clear) begin
            shown_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            shown_reg       <= '0;
            shown_units_reg <= '0;
            shown_valid_reg <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            shown_reg       <= shown_next;
            shown_units_reg <= shown_units_next;
            shown_valid_reg <= shown_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_angle_reg <= in_angle;
            s0_t_reg     <= t_sum;
            s0_q_reg     <= s0_q_next;
        end
        if (rdy[1]) begin
            s1_angle_reg  <= s0_angle_reg;
            s1_round_reg  <= s1_round_next;
            s1_runits_reg <= s1_runits_next;
        end
    end

    assign out_valid  = valid_reg[NST-1];
    assign out_tenths = shown_reg;

endmodule

`default_nettype wire

>>> rtl/core/angle_sensor_smooth_hysteresis_core.sv
// Top level of the angle sensor smoother: config registers and the datapath chain.
`default_nettype none

// Each accepted raw sample produces one displayed angle in tenths of a degree.
// The core takes one item per clock when the output side keeps up. A result
// passes one filter stage, seven stages for the scaling by turn/full-scale
// (reciprocal multiply, correction and wrap) and three for rounding and the
// hysteresis compare, the last of which is the result register. The filter and
// the shown value are updated as items pass their stage, so there is no
// per-item dependency stall. Config writes (cfg_ready is always high) restart
// the filter and the display on the next sample and must only be made while
// no item is in flight.
module angle_sensor_smooth_hysteresis_core #(
    parameter int SAMPLE_BITS  = ash_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_SHIFT = ash_pkg::FILTER_SHIFT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [SAMPLE_BITS-1:0] sample
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // m_tdata: [11:0] angle_tenths
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ash_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ash_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ash_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ash_pkg::*;

    logic [REF_W-1:0]        ref_raw_reg, ref_raw_next;
    logic [UNIT_W-1:0]       ref_units_reg, ref_units_next;
    logic [HYST_UNITS_W-1:0] hyst_units_reg, hyst_units_next;
    logic [TENTHS_W-1:0]     ref_clamped;
    logic                    cfg_hit;
    cfg_t                    cfg;

    logic                    filt_valid, filt_ready;
    logic [SAMPLE_BITS-1:0]  filt_pos;
    logic                    scale_valid, scale_ready;
    logic [UNIT_W-1:0]       scale_angle;
    logic [TENTHS_W-1:0]     disp_tenths;

    assign cfg_ready = 1'b1;

    // reference angle and band are kept pre-scaled to angle units
    always_comb begin
        ref_clamped = (cfg_data > CFG_DATA_W'(REF_TENTHS_MAX))
                      ? TENTHS_W'(REF_TENTHS_MAX) : TENTHS_W'(cfg_data);
        ref_raw_next    = ref_raw_reg;
        ref_units_next  = ref_units_reg;
        hyst_units_next = hyst_units_reg;
        cfg_hit         = 1'b0;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_REF_RAW: begin
                    ref_raw_next = REF_W'(cfg_data);
                    cfg_hit      = 1'b1;
                end
                CFG_REF_TENTHS: begin
                    ref_units_next = UNIT_W'(ref_clamped) * UNIT_W'(UNITS_PER_TENTH);
                    cfg_hit        = 1'b1;
                end
                CFG_HYST: begin
                    hyst_units_next = HYST_UNITS_W'(cfg_data[HYST_W-1:0])
                                      * HYST_UNITS_W'(HYST_SCALE);
                    cfg_hit         = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_raw_reg    <= '0;
            ref_units_reg  <= '0;
            hyst_units_reg <= HYST_UNITS_W'(HYST_RESET * HYST_SCALE);
        end else begin
            ref_raw_reg    <= ref_raw_next;
            ref_units_reg  <= ref_units_next;
            hyst_units_reg <= hyst_units_next;
        end
    end

    assign cfg.ref_raw    = ref_raw_reg;
    assign cfg.ref_units  = ref_units_reg;
    assign cfg.hyst_units = hyst_units_reg;

    ash_filter #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_hit),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .out_valid (filt_valid),
        .out_ready (filt_ready),
        .out_pos   (filt_pos)
    );

    ash_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (filt_valid),
        .in_ready  (filt_ready),
        .in_pos    (filt_pos),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_angle (scale_angle)
    );

    ash_disp u_disp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_hit),
        .cfg        (cfg),
        .in_valid   (scale_valid),
        .in_ready   (scale_ready),
        .in_angle   (scale_angle),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tenths (disp_tenths)
    );

    assign m_tdata = OUT_TDATA_W'(disp_tenths);

endmodule

`default_nettype wire

>>> rtl/core/ash_checker.sv
// Port-level assertions for the angle sensor smoother, bound to the top level.
`default_nettype none

module ash_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ash_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ash_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // shown angle stays within a full circle, inclusive of 360.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= OUT_TDATA_W'(REF_TENTHS_MAX)))
        else $error("angle out of range");

    // with the sink ready, every stage drains, so the input is never held off
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind angle_sensor_smooth_hysteresis_core ash_checker u_checker (.*);

`default_nettype wire
